>>> hdl/ust_pkg.sv
// Package for the update sequence tracker: phase and event codes, field widths
// and the sequencer state type. No dependencies.
package ust_pkg;

	// Default width of the size and received counters
	localparam int COUNT_WIDTH_DEF = 32;

	// Request field widths
	localparam int OP_W  = 3;
	localparam int ARG_W = 32;
	localparam int S_TDATA_W = ((OP_W + ARG_W + 7) / 8) * 8;

	// Result field widths
	localparam int PHASE_W = 3;
	localparam int PROG_W  = 7;
	localparam int M_TDATA_W = ((PHASE_W + PROG_W + 7) / 8) * 8;

	// Progress is a percentage
	localparam int PERCENT = 100;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE        = 3'd0,
		PH_CHECKING    = 3'd1,
		PH_DOWNLOADING = 3'd2,
		PH_VERIFYING   = 3'd3,
		PH_APPLYING    = 3'd4,
		PH_DONE        = 3'd5,
		PH_FAILED      = 3'd6
	} phase_t;

	typedef enum logic [OP_W-1:0] {
		EV_START      = 3'd0,
		EV_ACCEPT     = 3'd1,
		EV_REJECT     = 3'd2,
		EV_DATA       = 3'd3,
		EV_DOWNLOADED = 3'd4,
		EV_VERIFIED   = 3'd5,
		EV_APPLIED    = 3'd6,
		EV_FAIL       = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_SCALE,
		SQ_DIV,
		SQ_FINISH
	} seq_state_t;

endpackage

>>> hdl/update_sequence_tracker.sv
// Top level of the update sequence tracker: phase state machine and an
// iterative restoring divider for the progress percentage. Uses ust_pkg.
//
// Usage
// The slave channel (s_tvalid, s_tready, s_tdata) takes one event request at a
// time; the master channel (m_tvalid, m_tready, m_tdata) returns one result per
// event, giving the phase after the event and the progress percentage.
// The phase, total size and received count are updated in the cycle in which
// the request is accepted. The progress value is then worked out as
// received*100/total by a shared restoring divider that produces one quotient
// bit a cycle, followed by a clamp to 100.
// From acceptance the request passes through a scaling step that multiplies the
// count by 100, the divide steps, one per bit of the COUNT_WIDTH+7-bit dividend,
// and a finish step that clamps the quotient and loads the output register.
// s_tready is high only while the sequencer is idle, so one event is in work at
// a time and a new request is taken only once the previous result has been
// loaded into the output register.
// If the receiver stalls, the finished result waits in the sequencer until the
// output register is free; the output register holds its contents stable until
// m_tready is seen.
// Reset returns the phase to idle, clears both counters and empties the output
// register.
module update_sequence_tracker #(
	parameter int COUNT_WIDTH = ust_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata, from bit 0: op[2:0], arg[34:3], zero padding
	input  logic [ust_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata, from bit 0: phase[2:0], progress[9:3], zero padding
	output logic [ust_pkg::M_TDATA_W-1:0] m_tdata
);

	// Dividend width: count scaled by 100 needs seven more bits.
	localparam int DW    = COUNT_WIDTH + ust_pkg::PROG_W;
	localparam int CNT_W = $clog2(DW + 1);
	localparam logic [CNT_W-1:0] STEPS = CNT_W'(DW);
	localparam logic [ust_pkg::PROG_W-1:0] PCT_P = ust_pkg::PROG_W'(ust_pkg::PERCENT);
	localparam int PAD_W = ust_pkg::M_TDATA_W - ust_pkg::PHASE_W - ust_pkg::PROG_W;

	ust_pkg::seq_state_t state_q, state_nxt;

	ust_pkg::phase_t         phase_q, phase_nxt;
	logic [COUNT_WIDTH-1:0]  total_q, total_nxt;
	logic [COUNT_WIDTH-1:0]  recv_q, recv_nxt;

	// Divider: dvd_q shifts the dividend out and the quotient in.
	logic [DW-1:0]          dvd_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [COUNT_WIDTH:0]   trial;
	logic                   fits;
	logic [COUNT_WIDTH:0]   diff;

	logic [ust_pkg::PROG_W-1:0] progress;

	logic                         out_valid_q;
	logic [ust_pkg::M_TDATA_W-1:0] out_data_q;

	ust_pkg::op_t           op;
	logic [COUNT_WIDTH-1:0] arg;
	logic                   in_acc;
	logic                   out_load;

	assign op     = ust_pkg::op_t'(s_tdata[ust_pkg::OP_W-1:0]);
	assign arg    = s_tdata[ust_pkg::OP_W +: COUNT_WIDTH];
	assign in_acc = s_tvalid && s_tready;

	// Event handling: terminal phases absorb everything, fail aborts any
	// active phase, other events only act in the phase they belong to.
	always_comb begin
		phase_nxt = phase_q;
		total_nxt = total_q;
		recv_nxt  = recv_q;
		if (phase_q != ust_pkg::PH_DONE && phase_q != ust_pkg::PH_FAILED) begin
			if (op == ust_pkg::EV_FAIL) begin
				phase_nxt = ust_pkg::PH_FAILED;
			end else begin
				unique case (phase_q)
					ust_pkg::PH_IDLE: begin
						if (op == ust_pkg::EV_START) begin
							total_nxt = arg;
							recv_nxt  = '0;
							phase_nxt = ust_pkg::PH_CHECKING;
						end
					end
					ust_pkg::PH_CHECKING: begin
						if (op == ust_pkg::EV_ACCEPT)
							phase_nxt = ust_pkg::PH_DOWNLOADING;
						else if (op == ust_pkg::EV_REJECT)
							phase_nxt = ust_pkg::PH_IDLE;
					end
					ust_pkg::PH_DOWNLOADING: begin
						if (op == ust_pkg::EV_DATA)
							recv_nxt = recv_q + arg;
						else if (op == ust_pkg::EV_DOWNLOADED)
							phase_nxt = ust_pkg::PH_VERIFYING;
					end
					ust_pkg::PH_VERIFYING: begin
						if (op == ust_pkg::EV_VERIFIED)
							phase_nxt = ust_pkg::PH_APPLYING;
					end
					ust_pkg::PH_APPLYING: begin
						if (op == ust_pkg::EV_APPLIED)
							phase_nxt = ust_pkg::PH_DONE;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ust_pkg::PH_IDLE;
			total_q <= '0;
			recv_q  <= '0;
		end else if (in_acc) begin
			phase_q <= phase_nxt;
			total_q <= total_nxt;
			recv_q  <= recv_nxt;
		end
	end

	// One restoring step: bring down the next dividend bit and try the
	// subtraction.
	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, total_q};
	assign fits  = trial >= {1'b0, total_q};

	// Clamp the quotient to 100; an empty total gives zero.
	always_comb begin
		if (total_q == '0)
			progress = '0;
		else if ((|dvd_q[DW-1:ust_pkg::PROG_W]) || (dvd_q[ust_pkg::PROG_W-1:0] > PCT_P))
			progress = PCT_P;
		else
			progress = dvd_q[ust_pkg::PROG_W-1:0];
	end

	assign out_load = (state_q == ust_pkg::SQ_FINISH) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ust_pkg::SQ_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		unique case (state_q)
			ust_pkg::SQ_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_nxt = ust_pkg::SQ_SCALE;
			end
			ust_pkg::SQ_SCALE: begin
				state_nxt = ust_pkg::SQ_DIV;
			end
			ust_pkg::SQ_DIV: begin
				if (cnt_q == CNT_W'(1))
					state_nxt = ust_pkg::SQ_FINISH;
			end
			ust_pkg::SQ_FINISH: begin
				if (!out_valid_q || m_tready)
					state_nxt = ust_pkg::SQ_IDLE;
			end
			default: begin
				state_nxt = ust_pkg::SQ_IDLE;
			end
		endcase
	end

	// Divider datapath: scaling loads the dividend (count times 64 + 32 + 4),
	// each divide cycle yields one quotient bit.
	always_ff @(posedge clk) begin
		if (state_q == ust_pkg::SQ_SCALE) begin
			dvd_q <= (DW'(recv_q) << 6) + (DW'(recv_q) << 5) + (DW'(recv_q) << 2);
			rem_q <= '0;
			cnt_q <= STEPS;
		end else if (state_q == ust_pkg::SQ_DIV) begin
			dvd_q <= {dvd_q[DW-2:0], fits};
			rem_q <= fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_data_q <= {{PAD_W{1'b0}}, progress, phase_q};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> hdl/ust_checker.sv
// Port-level checker for the update sequence tracker, bound to the top level.
// Uses ust_pkg for field positions and codes.
module ust_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ust_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int PH_LO = 0;
	localparam int PG_LO = ust_pkg::PHASE_W;

	logic [ust_pkg::PHASE_W-1:0] res_phase;
	logic [ust_pkg::PROG_W-1:0]  res_prog;

	assign res_phase = m_tdata[PH_LO +: ust_pkg::PHASE_W];
	assign res_prog  = m_tdata[PG_LO +: ust_pkg::PROG_W];

	// A stalled result keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Progress is a clamped percentage.
	a_prog: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_prog <= ust_pkg::PROG_W'(ust_pkg::PERCENT))
		else $error("progress above one hundred");

	// The unused phase code never appears.
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_phase != {ust_pkg::PHASE_W{1'b1}})
		else $error("unused phase code on result");

	// Once a request is taken, s_tready stays low through the scale step and the first divide step.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("request taken while divider busy");

endmodule

bind update_sequence_tracker ust_checker u_ust_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> sim/ust_status_checker.sv
`timescale 1ns / 100ps
// Result checker for the update sequence tracker: it watches the event and result
// channels, keeps its own copy of the phase and counters and compares each result.
// Depends on ust_pkg.
module ust_status_checker #(
	parameter int COUNT_WIDTH = ust_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// s_tdata, from bit 0: op[2:0], arg[34:3], zero padding
	input  logic [ust_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata, from bit 0: phase[2:0], progress[9:3], zero padding
	input  logic [ust_pkg::M_TDATA_W-1:0] m_tdata,
	output int                            mismatches,
	output int                            pending,
	output int                            compared
);
	import ust_pkg::*;

	// Past this many reports only the count goes on.
	localparam int MAX_PRINTED = 30;

	typedef struct packed {
		phase_t            phase;
		logic [PROG_W-1:0] progress;
	} status_t;

	phase_t                 model_phase;
	logic [COUNT_WIDTH-1:0] model_size;
	logic [COUNT_WIDTH-1:0] model_received;
	status_t                status_q[$];

	function automatic logic [PROG_W-1:0] percent_done(input logic [COUNT_WIDTH-1:0] got,
		input logic [COUNT_WIDTH-1:0] whole);
		logic [63:0] ratio;
		if (whole == '0)
			return '0;
		ratio = (64'(got) * 64'(PERCENT)) / 64'(whole);
		if (ratio > 64'(PERCENT))
			ratio = 64'(PERCENT);
		return ratio[PROG_W-1:0];
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		status_t                got;
		status_t                want;
		op_t                    ev;
		logic [COUNT_WIDTH-1:0] arg;
		if (!arst_n) begin
			model_phase    = PH_IDLE;
			model_size     = '0;
			model_received = '0;
			status_q.delete();
			mismatches     = 0;
			compared       = 0;
			pending       <= 0;
		end else begin
			// Results are compared before the request of this edge is queued.
			if (m_tvalid && m_tready) begin
				got.phase    = phase_t'(m_tdata[PHASE_W-1:0]);
				got.progress = m_tdata[PHASE_W +: PROG_W];
				if (status_q.size() == 0) begin
					report_mismatch($sformatf("result phase %0d progress %0d with no request waiting",
						got.phase, got.progress));
				end else begin
					want = status_q.pop_front();
					compared++;
					if (got.phase !== want.phase)
						report_mismatch($sformatf("phase %0d, expected %0d", got.phase, want.phase));
					if (got.progress !== want.progress)
						report_mismatch($sformatf("progress %0d, expected %0d",
							got.progress, want.progress));
				end
			end
			if (s_tvalid && s_tready) begin
				ev  = op_t'(s_tdata[OP_W-1:0]);
				arg = COUNT_WIDTH'(s_tdata[OP_W +: ARG_W]);
				// Done and failed absorb every event.
				if (model_phase != PH_DONE && model_phase != PH_FAILED) begin
					if (ev == EV_FAIL) begin
						model_phase = PH_FAILED;
					end else begin
						case (model_phase)
							PH_IDLE: begin
								if (ev == EV_START) begin
									model_size     = arg;
									model_received = '0;
									model_phase    = PH_CHECKING;
								end
							end
							PH_CHECKING: begin
								if (ev == EV_ACCEPT)
									model_phase = PH_DOWNLOADING;
								else if (ev == EV_REJECT)
									model_phase = PH_IDLE;
							end
							PH_DOWNLOADING: begin
								if (ev == EV_DATA)
									model_received = model_received + arg;
								else if (ev == EV_DOWNLOADED)
									model_phase = PH_VERIFYING;
							end
							PH_VERIFYING: begin
								if (ev == EV_VERIFIED)
									model_phase = PH_APPLYING;
							end
							PH_APPLYING: begin
								if (ev == EV_APPLIED)
									model_phase = PH_DONE;
							end
							default: begin
							end
						endcase
					end
				end
				want.phase    = model_phase;
				want.progress = percent_done(model_received, model_size);
				status_q.push_back(want);
			end
			pending <= status_q.size();
		end
	end

endmodule

>>> sim/tb_update_sequence_tracker.sv
`timescale 1ns / 100ps
// Testbench top for the update sequence tracker: clock, reset, event stimulus and
// the result receiver; ust_status_checker does the prediction and comparison.
// Depends on ust_pkg, update_sequence_tracker and ust_status_checker.
module tb_update_sequence_tracker;
	import ust_pkg::*;

	// Well above the slowest correct run: about a thousand requests, each waiting
	// for the divider, plus random gaps, stalls and the long hold-off.
	localparam int CYCLE_LIMIT  = 400000;
	// Enough for one more result to surface after the last expected one.
	localparam int DRAIN_CYCLES = 60;

	// Request counts at which the idling pattern changes.
	localparam int PHASE1_END = 330;
	localparam int PHASE2_END = 660;

	// The receiver holds off once for a long stretch when this many requests
	// have gone in; the sender keeps offering meanwhile.
	localparam int HOLD_AT     = 720;
	localparam int HOLD_CYCLES = 400;

	localparam int LOOP_ITEMS     = 300;
	localparam int DOWNLOAD_ITEMS = 600;
	localparam int ABSORB_ITEMS   = 20;

	// Sets of events that leave the current phase alone, one bit per event code.
	// Fail is left out of all but the last, since it ends the update for good.
	localparam logic [7:0] IDLE_NOISE   = ~((8'd1 << EV_START) | (8'd1 << EV_FAIL));
	localparam logic [7:0] CHECK_NOISE  = ~((8'd1 << EV_ACCEPT) | (8'd1 << EV_REJECT) |
		(8'd1 << EV_FAIL));
	localparam logic [7:0] LOAD_NOISE   = ~((8'd1 << EV_DATA) | (8'd1 << EV_DOWNLOADED) |
		(8'd1 << EV_FAIL));
	localparam logic [7:0] VERIFY_NOISE = ~((8'd1 << EV_VERIFIED) | (8'd1 << EV_FAIL));
	localparam logic [7:0] APPLY_NOISE  = ~((8'd1 << EV_APPLIED) | (8'd1 << EV_FAIL));
	localparam logic [7:0] ALL_EVENTS   = 8'hFF;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// s_tdata, from bit 0: op[2:0], arg[34:3], zero padding
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// m_tdata, from bit 0: phase[2:0], progress[9:3], zero padding
	logic [M_TDATA_W-1:0] m_tdata;

	int mismatches;
	int pending;
	int compared;
	int req_count;
	int cycle_count = 0;
	int sent        = 0;

	update_sequence_tracker uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ust_status_checker status_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending),
		.compared   (compared)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Count of accepted requests, registered so that the receiver process sees
	// a stable value at every edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			req_count <= 0;
		else if (s_tvalid && s_tready)
			req_count <= req_count + 1;
	end

	// Watchdog: a run that has not finished by now has lost a result or hung.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offers one event request and waits until the block takes it. Before the
	// offer the sender may idle for a few cycles, more or less often according
	// to how far the run has got. The valid stays high when the next request
	// follows straight on.
	task automatic send_req(input op_t op, input logic [ARG_W-1:0] arg);
		int idle_pct;
		idle_pct = (sent < PHASE1_END) ? 15 : (sent < PHASE2_END) ? 87 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'({arg, op});
		do
			@(posedge clk);
		while (!s_tready);
		sent++;
	endtask

	// Sends a number of events drawn from the given set, with random arguments.
	task automatic send_noise(input int count, input logic [7:0] allowed);
		op_t op;
		for (int i = 0; i < count; i++) begin
			do
				op = op_t'($urandom_range(0, 7));
			while (!allowed[op]);
			send_req(op, $urandom());
		end
	endtask

	// Total sizes: the extremes, small and medium values and the full range.
	function automatic logic [ARG_W-1:0] pick_size();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return $urandom_range(1, 1000);
			3: return $urandom_range(1000, 1000000);
			default: return $urandom();
		endcase
	endfunction

	// The receiver: mostly random stalls, heavy while the sender is busy and
	// light while the sender idles, none at all near the end. Once in the run it
	// holds off for a long stretch, so that the finished result and the one in
	// work back up and the block stops taking requests.
	initial begin
		int stall_pct;
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			stall_pct = (req_count < PHASE1_END) ? 87 : (req_count < PHASE2_END) ? 15 : 0;
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && req_count >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Stimulus. There is no way out of done or failed short of a reset, and no
	// way back from downloading, so the run is laid out as one update: many
	// start and reject loops first, then one accepted download with a long run
	// of data, then a finish through done or through fail, chosen at random.
	initial begin
		logic [ARG_W-1:0] total;
		logic [ARG_W-1:0] step;
		int               finish_path;
		int               r;
		string            path_name;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: events that are not valid in idle or checking, a start
		// with a zero total (progress must read zero, not a divide-by-zero
		// quotient), starts with the largest and other edge sizes, a start
		// while already checking, and rejects that go back to idle.
		send_req(EV_DATA, '1);
		send_req(EV_ACCEPT, '0);
		send_req(EV_APPLIED, '1);
		send_req(EV_START, '0);
		send_req(EV_DATA, 32'h0000_0001);
		send_req(EV_REJECT, '0);
		send_req(EV_REJECT, '1);
		send_req(EV_START, '1);
		send_req(EV_START, 32'd5);
		send_req(EV_DOWNLOADED, '1);
		send_req(EV_VERIFIED, '0);
		send_req(EV_REJECT, '1);
		send_req(EV_START, 32'd1);
		send_req(EV_REJECT, 32'h8000_0000);
		send_req(EV_START, 32'h8000_0000);
		send_req(EV_REJECT, 32'h7FFF_FFFF);

		// Start and reject loops with ignored events in between.
		while (sent < LOOP_ITEMS) begin
			send_noise($urandom_range(0, 3), IDLE_NOISE);
			send_req(EV_START, pick_size());
			send_noise($urandom_range(0, 3), CHECK_NOISE);
			send_req(EV_REJECT, $urandom());
		end

		// The accepted download. Most chunks are small against the total, so
		// the percentage climbs through its range; large chunks push the count
		// past the total, where it saturates, and around the top of its width.
		do
			total = pick_size();
		while (total == '0);
		send_req(EV_START, total);
		send_noise($urandom_range(0, 2), CHECK_NOISE);
		send_req(EV_ACCEPT, $urandom());
		step = (total / 25) + 1;
		for (int i = 0; i < DOWNLOAD_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				send_noise(1, LOAD_NOISE);
			else if (r < 70)
				send_req(EV_DATA, $urandom_range(0, step));
			else if (r < 85)
				send_req(EV_DATA, $urandom());
			else if (r < 92)
				send_req(EV_DATA, '0);
			else
				send_req(EV_DATA, '1);
		end

		// The finish: a fail from downloading, verifying or applying, or the
		// full path to done. The counts are kept through a fail.
		finish_path = $urandom_range(0, 3);
		send_noise($urandom_range(0, 3), LOAD_NOISE);
		if (finish_path == 0) begin
			send_req(EV_FAIL, $urandom());
		end else begin
			send_req(EV_DOWNLOADED, $urandom());
			send_noise($urandom_range(0, 3), VERIFY_NOISE);
			if (finish_path == 1) begin
				send_req(EV_FAIL, $urandom());
			end else begin
				send_req(EV_VERIFIED, $urandom());
				send_noise($urandom_range(0, 3), APPLY_NOISE);
				send_req((finish_path == 2) ? EV_FAIL : EV_APPLIED, $urandom());
			end
		end

		// Terminal phase: every event, a fail among them, must leave it alone.
		send_req(EV_FAIL, '1);
		send_noise(ABSORB_ITEMS, ALL_EVENTS);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		case (finish_path)
			0: path_name = "a fail while downloading";
			1: path_name = "a fail while verifying";
			2: path_name = "a fail while applying";
			default: path_name = "the full path to done";
		endcase
		$display("Summary: %0d event requests sent, %0d results compared, %0d mismatches.",
			sent, compared, mismatches);
		$display("Covered start/reject loops, one download of %0d bytes, and %s.",
			total, path_name);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
